// ===== hw/rtl/aos_pkg.sv =====
// Shared types, constants and tone tables for the alarm output sequencer.
// No dependencies; used by every module of the block.
package aos_pkg;

  localparam int unsigned MELODY_LEN = 20;
  localparam int unsigned TABLE_LEN  = 20;

  localparam logic [15:0] BLINK_RESET = 16'd500;

  localparam logic [6:0] LONG_MS    = 7'd90;
  localparam logic [6:0] SHORT_MS   = 7'd67;
  // next-note spacing minus one, loaded into the wait counter
  localparam logic [7:0] LONG_WAIT  = 8'd161;
  localparam logic [7:0] SHORT_WAIT = 8'd119;
  localparam logic [7:0] GAP_WAIT   = 8'd99;

  typedef struct packed {
    logic snooze;
    logic radio_request;
    logic buzzer_request;
    logic light_request;
    logic beep_request;
  } tick_t;

  typedef struct packed {
    logic       radio_on;
    logic       buzzer_pin;
    logic       light_pin;
    logic       beep_on;
    logic       note_start;
    logic [9:0] note_hz;
    logic [6:0] note_ms;
    logic       any_active;
  } result_t;

  typedef struct packed {
    logic       start;
    logic [9:0] hz;
    logic [6:0] ms;
  } note_t;

  function automatic logic [9:0] tone_hz(input logic [4:0] idx);
    logic [9:0] hz;
    unique case (idx)
      5'd0, 5'd1, 5'd2, 5'd4, 5'd5, 5'd7, 5'd9: hz = 10'd523;
      5'd3, 5'd6, 5'd8:                         hz = 10'd294;
      5'd10, 5'd11, 5'd12, 5'd14, 5'd15, 5'd17, 5'd19: hz = 10'd494;
      5'd13, 5'd18:                             hz = 10'd131;
      5'd16:                                    hz = 10'd33;
      default:                                  hz = 10'd523;
    endcase
    return hz;
  endfunction

  function automatic logic tone_long(input logic [4:0] idx);
    logic is_long;
    unique case (idx)
      5'd0, 5'd1, 5'd2, 5'd5, 5'd9,
      5'd10, 5'd11, 5'd12, 5'd15, 5'd19: is_long = 1'b1;
      default:                           is_long = 1'b0;
    endcase
    return is_long;
  endfunction

endpackage

// ===== hw/rtl/aos_melody.sv =====
// Melody sequencer: note position and spacing counter, one step per tick item.
// Depends on aos_pkg for the tone tables and timing constants.
module aos_melody import aos_pkg::*; #(
  parameter int unsigned MelodyLen = MELODY_LEN
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  logic  beep_old,
  input  logic  beep_new,
  output note_t note
);

  localparam int unsigned PosW = $clog2(MelodyLen + 1);

  logic [PosW-1:0] melody_pos, melody_pos_next;
  logic [7:0]      wait_left, wait_left_next;
  logic [PosW-1:0] pos_cur;
  logic [7:0]      wait_cur;
  logic [5:0]      pos6;
  logic [4:0]      idx;
  logic            rise;
  logic            is_long;

  assign rise     = beep_new & ~beep_old;
  // restart from note 0 on the same tick the enable rises
  assign pos_cur  = rise ? '0 : melody_pos;
  assign wait_cur = rise ? '0 : wait_left;
  assign pos6     = 6'(pos_cur);

  always_comb begin
    if (pos6 >= 6'(TABLE_LEN)) begin
      idx = 5'(pos6 - 6'(TABLE_LEN));
    end else begin
      idx = 5'(pos6);
    end
    if (idx >= 5'(TABLE_LEN)) begin
      idx = '0;
    end
  end

  assign is_long = tone_long(idx);

  always_comb begin
    melody_pos_next = melody_pos;
    wait_left_next  = wait_left;
    note            = '0;
    if (beep_new) begin
      priority if (wait_cur != '0) begin
        wait_left_next  = wait_cur - 8'd1;
        melody_pos_next = pos_cur;
      end else if (pos_cur >= PosW'(MelodyLen)) begin
        wait_left_next  = GAP_WAIT;
        melody_pos_next = '0;
      end else begin
        note.start      = 1'b1;
        note.hz         = tone_hz(idx);
        note.ms         = is_long ? LONG_MS : SHORT_MS;
        wait_left_next  = is_long ? LONG_WAIT : SHORT_WAIT;
        melody_pos_next = pos_cur + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      melody_pos <= '0;
      wait_left  <= '0;
    end else if (step) begin
      melody_pos <= melody_pos_next;
      wait_left  <= wait_left_next;
    end
  end

endmodule

// ===== hw/rtl/alarm_output_sequencer_core.sv =====
// Top level of the alarm output sequencer: enables, blink timing, output buffer.
// Depends on aos_pkg and instantiates aos_melody.
//
// Usage: each item on the tick channel is one millisecond tick carrying a
// snooze bit and four alarm requests. For every accepted tick the block
// delivers exactly one result item on the result channel: the four enables
// after the tick (buzzer and light gated by the blink phase), a note-start
// pulse with pitch and length, and an OR of the enables.
// A tick is taken when tick_valid is high and tick_stall low; a result is
// taken when result_valid is high and result_stall low.
// A tick's result is formed combinationally and written into the buffer on
// acceptance. Throughput is one tick per cycle while tick_stall is low; all
// per-tick work is a single level of counter and table logic before the buffer.
// The result side has a two-entry buffer, so a tick is still accepted while
// one finished result waits; tick_stall rises only when both entries hold
// results that the receiver has not taken.
// blink_interval is written through cfg_valid/cfg_data (cfg_ready is always
// high) and should change only while no tick is in flight.
// Reset clears the blink counter and phase, the enables, the melody position
// and wait counter, empties the buffer and loads blink_interval with 500.
module alarm_output_sequencer_core import aos_pkg::*; #(
  parameter int unsigned MelodyLen = MELODY_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_stall,
  input  tick_t       tick,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] blink_interval;
  logic [15:0] blink_count;
  logic        blink_phase;
  logic [3:0]  enables;       // bit0 radio, bit1 buzzer, bit2 light, bit3 beep
  logic [3:0]  enables_next;
  logic        accept;
  logic        take;
  logic        wrap;
  logic        even;
  note_t       note;
  result_t     res_next;
  result_t     skid;
  logic        skid_valid;

  assign cfg_ready  = 1'b1;
  assign tick_stall = skid_valid;
  assign accept     = tick_valid & ~tick_stall;
  assign take       = result_valid & ~result_stall;

  assign enables_next = tick.snooze ? 4'b0000 :
                        {tick.beep_request, tick.light_request,
                         tick.buzzer_request, tick.radio_request};
  assign even = ~blink_phase;
  assign wrap = ({1'b0, blink_count} + 17'd1) >= {1'b0, blink_interval};

  aos_melody #(
    .MelodyLen(MelodyLen)
  ) u_melody (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .beep_old(enables[3]),
    .beep_new(enables_next[3]),
    .note    (note)
  );

  always_comb begin
    res_next.radio_on   = enables_next[0];
    res_next.buzzer_pin = enables_next[1] & even;
    res_next.light_pin  = enables_next[2] & even;
    res_next.beep_on    = enables_next[3];
    res_next.note_start = note.start;
    res_next.note_hz    = note.hz;
    res_next.note_ms    = note.ms;
    res_next.any_active = |enables_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_interval <= BLINK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blink_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_count <= '0;
      blink_phase <= 1'b0;
      enables     <= '0;
    end else if (accept) begin
      enables <= enables_next;
      if (wrap) begin
        blink_count <= '0;
        blink_phase <= ~blink_phase;
      end else begin
        blink_count <= blink_count + 16'd1;
      end
    end
  end

  // two-entry result buffer: head register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      if (!result_valid) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        result <= skid;
      end else begin
        result <= res_next;
      end
    end else if (accept) begin
      if (!result_valid) begin
        result <= res_next;
      end else begin
        skid <= res_next;
      end
    end
  end

endmodule

// ===== hw/rtl/aos_checker.sv =====
// Port-level checks for the alarm output sequencer, bound to the top level.
// Depends on aos_pkg for the result item type.
module aos_checker import aos_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // a stalled result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // pitch and length only with a note start
  a_no_note: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.note_start |-> result.note_hz == '0 && result.note_ms == '0)
    else $error("note fields set without note start");

  // a note only plays while the melody is enabled, with a legal length
  a_note_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.note_start |->
      result.beep_on && (result.note_ms == LONG_MS || result.note_ms == SHORT_MS))
    else $error("bad note start");

  // no output line may be on when no alarm is active
  a_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.any_active |->
      !result.radio_on && !result.buzzer_pin && !result.light_pin && !result.beep_on)
    else $error("output on while inactive");

endmodule

bind alarm_output_sequencer_core aos_checker u_aos_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

// ===== tb/alarm_output_sequencer_core_tb.sv =====
// Self-checking testbench for alarm_output_sequencer_core: tick items in,
// one predicted result item per tick checked in order. Depends on aos_pkg.
module alarm_output_sequencer_core_tb;
  import aos_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 60;

  localparam logic [9:0] PITCH_HZ [TABLE_LEN] = '{
    10'd523, 10'd523, 10'd523, 10'd294, 10'd523, 10'd523, 10'd294, 10'd523, 10'd294, 10'd523,
    10'd494, 10'd494, 10'd494, 10'd131, 10'd494, 10'd494, 10'd33,  10'd494, 10'd131, 10'd494
  };
  // bit n set: note n is a long beat
  localparam logic [TABLE_LEN-1:0] LONG_NOTES = 20'b1000_1001_1110_0010_0111;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_stall;
  tick_t       tick = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // sequencer state as predicted
  logic [15:0] blink_len;
  logic [15:0] blink_cnt;
  logic        blink_odd;
  logic [3:0]  alarm_en;
  int unsigned note_pos;
  logic [7:0]  note_wait;

  result_t     tick_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_taken = 0;
  int unsigned hold_left = 0;

  alarm_output_sequencer_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("alarm_output_sequencer_core test failed");
      $finish;
    end
  end

  function automatic result_t step_sequencer(input tick_t t);
    result_t     r;
    logic [3:0]  next_en;
    logic        even;
    int unsigned idx;
    r = '0;
    next_en = t.snooze ? 4'b0000
                       : {t.beep_request, t.light_request, t.buzzer_request, t.radio_request};
    even = !blink_odd;
    if (next_en[3]) begin
      // restart the melody on a rising beep enable
      if (!alarm_en[3]) begin
        note_pos = 0;
        note_wait = '0;
      end
      if (note_wait != 0) begin
        note_wait = note_wait - 8'd1;
      end else if (note_pos >= MELODY_LEN) begin
        note_wait = GAP_WAIT;
        note_pos = 0;
      end else begin
        idx = note_pos % TABLE_LEN;
        r.note_start = 1'b1;
        r.note_hz = PITCH_HZ[idx];
        if (LONG_NOTES[idx]) begin
          r.note_ms = LONG_MS;
          note_wait = LONG_WAIT;
        end else begin
          r.note_ms = SHORT_MS;
          note_wait = SHORT_WAIT;
        end
        note_pos = note_pos + 1;
      end
    end
    alarm_en = next_en;
    // interval 0 behaves like 1 through the same compare
    if ({1'b0, blink_cnt} + 17'd1 >= {1'b0, blink_len}) begin
      blink_cnt = '0;
      blink_odd = !blink_odd;
    end else begin
      blink_cnt = blink_cnt + 16'd1;
    end
    r.radio_on = next_en[0];
    r.buzzer_pin = next_en[1] & even;
    r.light_pin = next_en[2] & even;
    r.beep_on = next_en[3];
    r.any_active = |next_en;
    return r;
  endfunction

  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      holds_taken <= holds_taken + 1;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (tick_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cycle %0d: result item with none pending", cycle_count);
      end else begin
        want = tick_results.pop_front();
        if (result.radio_on !== want.radio_on || result.buzzer_pin !== want.buzzer_pin ||
            result.light_pin !== want.light_pin || result.beep_on !== want.beep_on ||
            result.note_start !== want.note_start || result.note_hz !== want.note_hz ||
            result.note_ms !== want.note_ms || result.any_active !== want.any_active) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("cycle %0d: want radio %0b buzz %0b light %0b beep %0b start %0b %s",
                     cycle_count, want.radio_on, want.buzzer_pin, want.light_pin,
                     want.beep_on, want.note_start, "");
            $display("  want hz %0d ms %0d any %0b, got radio %0b buzz %0b light %0b",
                     want.note_hz, want.note_ms, want.any_active,
                     result.radio_on, result.buzzer_pin, result.light_pin);
            $display("  got beep %0b start %0b hz %0d ms %0d any %0b",
                     result.beep_on, result.note_start, result.note_hz, result.note_ms,
                     result.any_active);
          end
        end
      end
    end
  end

  // Keep valid high across back-to-back items; drop it only for a gap.
  task automatic send_tick(input tick_t t);
    if (!steady) begin
      while ($urandom_range(99) < 7) begin
        tick_valid <= 1'b0;
        @(posedge clk);
      end
    end
    tick_valid <= 1'b1;
    tick <= t;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    tick_results.push_back(step_sequencer(t));
  endtask

  task automatic drain;
    tick_valid <= 1'b0;
    while (tick_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_interval(input logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    blink_len = value;
    cfg_valid <= 1'b0;
  endtask

  // beep held, other requests random, rare snooze when asked
  function automatic tick_t melody_tick(input bit with_snooze);
    tick_t t;
    t = tick_t'(5'($urandom_range(31)));
    t.beep_request = 1'b1;
    t.snooze = with_snooze && ($urandom_range(49) == 0);
    return t;
  endfunction

  task automatic test_request_bits;
    send_tick(tick_t'(5'b0_0000));
    send_tick(tick_t'(5'b0_1000));   // radio
    send_tick(tick_t'(5'b0_0100));   // buzzer
    send_tick(tick_t'(5'b0_0010));   // light
    send_tick(tick_t'(5'b0_0001));   // beep rises, note 0
    send_tick(tick_t'(5'b0_1111));
    send_tick(tick_t'(5'b1_1111));   // snooze overrides all
    send_tick(tick_t'(5'b1_0000));
    send_tick(tick_t'(5'b0_1111));
  endtask

  task automatic test_melody_restart;
    repeat (4) send_tick(tick_t'(5'b0_0001));
    send_tick(tick_t'(5'b1_0001));   // snooze clears beep
    repeat (3) send_tick(tick_t'(5'b0_0001));
    send_tick(tick_t'(5'b0_1110));   // beep drops
    repeat (2) send_tick(tick_t'(5'b0_0001));
  endtask

  task automatic test_interval_extremes;
    set_interval(16'd1);
    repeat (6) send_tick(tick_t'(5'b0_0110));
    set_interval(16'd0);
    repeat (6) send_tick(tick_t'(5'b0_0110));
    set_interval(16'hFFFF);
    repeat (6) send_tick(tick_t'(5'b0_0111));
  endtask

  // Count is past the new interval, so the blink phase flips on the next tick.
  task automatic test_interval_shrink;
    set_interval(16'd200);
    repeat (40) send_tick(tick_t'(5'b0_0110));
    set_interval(16'd3);
    repeat (8) send_tick(tick_t'(5'b0_0110));
  endtask

  task automatic test_melody_long;
    set_interval(16'($urandom_range(1, 20)));
    // a long stretch of notes with beep held throughout
    repeat (400) send_tick(melody_tick(1'b0));
  endtask

  task automatic random_phase(input logic [15:0] interval, input int unsigned count,
                              input bit with_hold);
    int unsigned sent;
    int unsigned burst;
    set_interval(interval);
    // receiver holds off while ticks keep coming
    if (with_hold) holds_asked++;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(3) != 0) begin
        burst = $urandom_range(20, 200);
        if (burst > count - sent) burst = count - sent;
        repeat (burst) send_tick(melody_tick(1'b1));
      end else begin
        burst = $urandom_range(1, 20);
        if (burst > count - sent) burst = count - sent;
        repeat (burst) send_tick(tick_t'(5'($urandom_range(31))));
      end
      sent += burst;
    end
  endtask

  task automatic test_random;
    random_phase(16'd2, 200, 1'b0);
    steady = 1'b1;
    random_phase(16'($urandom_range(1, 64)), 200, 1'b0);
    steady = 1'b0;
    random_phase(BLINK_RESET, 200, 1'b1);
    random_phase(16'($urandom_range(1, 16'hFFFF)), 200, 1'b0);
  endtask

  initial begin
    blink_len = BLINK_RESET;
    blink_cnt = '0;
    blink_odd = 1'b0;
    alarm_en = '0;
    note_pos = 0;
    note_wait = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_request_bits();
    test_melody_restart();
    test_interval_extremes();
    test_interval_shrink();
    test_melody_long();
    test_random();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("alarm_output_sequencer_core test passed");
    end else begin
      $display("alarm_output_sequencer_core test failed");
    end
    $finish;
  end

endmodule
